[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[src/rlelm_pkg.sv]
package rlelm_pkg;
   localparam int DEF_MAX_WIDTH = 4096;
   localparam int DEF_MAX_LINES = 4096;
   localparam int CFG_W = 13;
   localparam int COL_W = 12;
   localparam int LEN_W = 13;
   localparam int FIELD_W = 9;

   typedef enum logic [1:0] {
      CSR_LINE_WIDTH = 2'd0,
      CSR_LINE_TOTAL = 2'd1,
      CSR_PIXEL_BITS = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_BG, PH_MODE, PH_START, PH_END, PH_FLAG,
      PH_LEN, PH_COPYLEN, PH_VAL, PH_ZVAL
   } phase_type;

   typedef enum logic [2:0] {
      MODE_EMPTY, MODE_BASIC, MODE_DELTA, MODE_BASIC_STOP,
      MODE_START_END, MODE_DELTA_STOP, MODE_BASIC_ZERO, MODE_BAD
   } mode_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [LEN_W-1:0] length;
      logic             kind;
      logic [7:0]       value;
      logic             last_line;
      logic             last_image;
      logic             error;
   } token_type;

   typedef struct packed {
      logic [CFG_W-1:0] width;
      logic [CFG_W-1:0] total;
      logic [3:0]       bits;
   } geom_type;
endpackage

[src/rlelm_csr.sv]
module rlelm_csr #(
   parameter int MAX_WIDTH = rlelm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_LINES = rlelm_pkg::DEF_MAX_LINES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [rlelm_pkg::CFG_W-1:0] csr_data,
   output rlelm_pkg::geom_type         geom
);
   import rlelm_pkg::*;

   logic [CFG_W-1:0] width_ff, total_ff;
   logic [3:0]       bits_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= CFG_W'(1);
         total_ff <= CFG_W'(1);
         bits_ff  <= 4'd8;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_LINE_WIDTH: width_ff <= csr_data;
            CSR_LINE_TOTAL: total_ff <= csr_data;
            CSR_PIXEL_BITS: bits_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Clamp to the legal ranges so the parser sees effective values.
   always_comb begin
      geom.width = width_ff;
      if (width_ff == '0) geom.width = CFG_W'(1);
      else if (32'(width_ff) > MAX_WIDTH) geom.width = CFG_W'(MAX_WIDTH);
      geom.total = total_ff;
      if (total_ff == '0) geom.total = CFG_W'(1);
      else if (32'(total_ff) > MAX_LINES) geom.total = CFG_W'(MAX_LINES);
      geom.bits = bits_ff;
      if (bits_ff == '0) geom.bits = 4'd1;
      else if (bits_ff > 4'd8) geom.bits = 4'd8;
   end
endmodule

[src/rlelm_parser.sv]
module rlelm_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  bit_in,
   input  logic                  sop,
   input  rlelm_pkg::geom_type   geom,
   output logic                  emit,
   output rlelm_pkg::token_type  token,
   output logic                  halted
);
   import rlelm_pkg::*;

   phase_type        phase_ff, phase_in;
   mode_type         mode_ff, mode_in;
   logic [FIELD_W-1:0] shift_ff, shift_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [LEN_W-1:0] left_ff, left_in, pend_ff, pend_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [CFG_W-1:0] line_ff, line_in;
   logic [7:0]       bg_ff, bg_in, held_ff, held_in;
   logic             halt_ff, halt_in;

   assign halted = halt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BG;
         mode_ff  <= MODE_EMPTY;
         shift_ff <= '0;
         cnt_ff   <= '0;
         left_ff  <= '0;
         pend_ff  <= '0;
         col_ff   <= '0;
         line_ff  <= '0;
         bg_ff    <= '0;
         held_ff  <= '0;
         halt_ff  <= 1'b1;
      end else if (step) begin
         phase_ff <= phase_in;
         mode_ff  <= mode_in;
         shift_ff <= shift_in;
         cnt_ff   <= cnt_in;
         left_ff  <= left_in;
         pend_ff  <= pend_in;
         col_ff   <= col_in;
         line_ff  <= line_in;
         bg_ff    <= bg_in;
         held_ff  <= held_in;
         halt_ff  <= halt_in;
      end
   end

   phase_type        ph;
   mode_type         md;
   logic [FIELD_W-1:0] sh, v;
   logic [3:0]       ct, need;
   logic [LEN_W-1:0] lf, len;
   logic [COL_W-1:0] cl;
   logic [CFG_W-1:0] ln;
   logic [7:0]       bg, hv;
   logic             hl, do_run, can_end, run_kind, fail, mark, endrun;
   logic [7:0]       run_val;
   logic [LEN_W-1:0] left_after;
   logic [CFG_W-1:0] line_next;
   logic             final_line;

   always_comb begin
      ph = phase_ff; md = mode_ff; sh = shift_ff; ct = cnt_ff;
      lf = left_ff; cl = col_ff; ln = line_ff; bg = bg_ff; hv = held_ff;
      hl = halt_ff;
      if (sop) begin
         hl = 1'b0; ph = PH_BG; md = MODE_EMPTY; sh = '0; ct = '0;
         lf = '0; cl = '0; ln = '0; bg = '0; hv = '0;
      end
      // Bits needed by the field being collected.
      unique case (ph)
         PH_MODE:    need = 4'd3;
         PH_START:   need = (md == MODE_START_END) ? 4'd9 : 4'd8;
         PH_END:     need = 4'd8;
         PH_FLAG:    need = 4'd1;
         PH_COPYLEN: need = (md == MODE_DELTA_STOP) ? 4'd5 : 4'd6;
         PH_LEN: begin
            unique case (md)
               MODE_BASIC:      need = 4'd4;
               MODE_BASIC_STOP: need = 4'd6;
               MODE_BASIC_ZERO: need = (hv == bg) ? 4'd8 : 4'd3;
               default:         need = 4'd3;
            endcase
         end
         default: need = geom.bits;
      endcase
      v = sh;
      if (ct < 4'(FIELD_W)) v[ct[$clog2(FIELD_W)-1:0]] = bit_in;

      phase_in = ph; mode_in = md; held_in = hv; bg_in = bg;
      pend_in = pend_ff; shift_in = v; cnt_in = ct + 4'd1;
      left_in = lf; col_in = cl; line_in = ln; halt_in = hl;
      emit = 1'b0; token = '0;
      do_run = 1'b0; can_end = 1'b1; run_kind = 1'b0; run_val = bg;
      len = '0; fail = 1'b0; mark = 1'b0; endrun = 1'b0;
      line_next = ln + CFG_W'(1);
      final_line = line_next >= geom.total;
      left_after = lf;

      if (hl) begin
         shift_in = sh; cnt_in = ct;
      end else if (ct + 4'd1 >= need) begin
         shift_in = '0; cnt_in = '0;
         unique case (ph)
            PH_BG: begin
               bg_in = v[7:0]; phase_in = PH_MODE; col_in = '0;
               left_in = geom.width;
            end
            PH_MODE: begin
               mode_in = mode_type'(v[2:0]);
               unique case (mode_type'(v[2:0]))
                  MODE_EMPTY: begin do_run = 1'b1; len = lf; end
                  MODE_BASIC: phase_in = PH_LEN;
                  MODE_DELTA, MODE_DELTA_STOP: phase_in = PH_FLAG;
                  MODE_BASIC_STOP, MODE_START_END: phase_in = PH_START;
                  MODE_BASIC_ZERO: phase_in = PH_ZVAL;
                  default: fail = 1'b1;
               endcase
            end
            PH_START: begin
               phase_in = (md == MODE_START_END) ? PH_END : PH_LEN;
               if (v != '0) begin
                  if (LEN_W'(v) > lf) fail = 1'b1;
                  else begin
                     do_run = 1'b1; len = LEN_W'(v);
                     can_end = (md != MODE_START_END);
                  end
               end
            end
            PH_END: begin
               if (LEN_W'(v) > lf) fail = 1'b1;
               else begin
                  phase_in = PH_LEN;
                  if (v == '0) mark = (lf == '0);
                  else endrun = 1'b1;
               end
            end
            PH_FLAG: phase_in = v[0] ? PH_COPYLEN : PH_LEN;
            PH_COPYLEN: begin
               len = LEN_W'(v) + LEN_W'(1);
               if (len > lf) fail = 1'b1;
               else begin
                  phase_in = PH_FLAG; do_run = 1'b1;
                  if (ln != '0) begin run_kind = 1'b1; run_val = '0; end
               end
            end
            PH_LEN: begin
               if ((md == MODE_BASIC_STOP || md == MODE_DELTA_STOP) && v == '0)
                  mark = 1'b1;
               else begin
                  if (md == MODE_BASIC_STOP || md == MODE_DELTA_STOP)
                     len = LEN_W'(v);
                  else
                     len = LEN_W'(v) + LEN_W'(1);
                  if (len > lf) fail = 1'b1;
                  else if (md == MODE_BASIC_ZERO) begin
                     phase_in = PH_ZVAL; do_run = 1'b1; run_val = hv;
                  end else begin
                     pend_in = len; phase_in = PH_VAL;
                  end
               end
            end
            PH_VAL: begin
               if (md == MODE_DELTA || md == MODE_DELTA_STOP) phase_in = PH_FLAG;
               else if (md == MODE_BASIC_ZERO) phase_in = PH_ZVAL;
               else phase_in = PH_LEN;
               do_run = 1'b1; len = pend_ff; run_val = v[7:0];
            end
            PH_ZVAL: begin
               held_in = v[7:0]; phase_in = PH_LEN;
            end
            default: fail = 1'b1;
         endcase

         // An error halts the image; a closed line either halts the image or restarts the next line.
         if (fail) begin
            emit = 1'b1; token.error = 1'b1; halt_in = 1'b1;
         end else if (mark) begin
            emit = 1'b1;
            token.column = cl; token.value = bg; token.last_line = 1'b1;
            token.last_image = final_line;
            line_in = line_next;
            if (final_line) halt_in = 1'b1;
            else begin phase_in = PH_MODE; col_in = '0; left_in = geom.width; end
         end else if (do_run || endrun) begin
            emit = 1'b1;
            left_after = lf - len;
            token.length = len; token.kind = run_kind; token.value = run_val;
            if (endrun) begin
               token.length = LEN_W'(v); token.value = bg;
               left_after = lf - LEN_W'(v);
               token.column = cl + COL_W'(lf) - COL_W'(v);
            end else begin
               token.column = cl;
               col_in = cl + COL_W'(len);
            end
            left_in = left_after;
            if ((endrun || can_end) && left_after == '0) begin
               token.last_line = 1'b1;
               token.last_image = final_line;
               line_in = line_next;
               if (final_line) halt_in = 1'b1;
               else begin
                  phase_in = PH_MODE; col_in = '0; left_in = geom.width;
               end
            end
         end
      end
   end
endmodule

[src/rle_line_mode_decoder.sv]
// Channel  Direction  Beat carries
// req      in         stream_bit, start_of_image
// rsp      out        one run token (column, length, kind, value, last flags, error)
// csr      in         register index and write data
// One beat per cycle while req_ready is high; a token it emits is registered.
// The rate is set by the single parse step between the bit input and the token register.
// Reset is synchronous; afterwards the parser waits for a start_of_image beat.
// A stalled rsp holds its token and req_ready drops only while that token is held.
module rle_line_mode_decoder #(
   parameter int MAX_WIDTH = rlelm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_LINES = rlelm_pkg::DEF_MAX_LINES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_stream_bit,
   input  logic        req_start_of_image,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_run_column,
   output logic [12:0] rsp_run_length,
   output logic        rsp_run_kind,
   output logic [7:0]  rsp_fill_value,
   output logic        rsp_last_of_line,
   output logic        rsp_last_of_image,
   output logic        rsp_error_flag,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);
   import rlelm_pkg::*;
`include "assert_macros.svh"

   geom_type  geom;
   token_type token, tok_ff;
   logic      emit, step, halted, valid_ff;

   rlelm_csr #(.MAX_WIDTH(MAX_WIDTH), .MAX_LINES(MAX_LINES)) u_csr (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data, .geom
   );

   assign req_ready = !valid_ff || rsp_ready;
   assign step = req_valid && req_ready;

   rlelm_parser u_parser (
      .clock, .reset, .step, .bit_in(req_stream_bit), .sop(req_start_of_image),
      .geom, .emit, .token, .halted
   );

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (step) valid_ff <= emit;
      else if (rsp_ready) valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (step && emit) tok_ff <= token;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_run_column    = tok_ff.column;
   assign rsp_run_length    = tok_ff.length;
   assign rsp_run_kind      = tok_ff.kind;
   assign rsp_fill_value    = tok_ff.value;
   assign rsp_last_of_line  = tok_ff.last_line;
   assign rsp_last_of_image = tok_ff.last_image;
   assign rsp_error_flag    = tok_ff.error;

   `ASSERT_NEXT(a_err_halts, clock, reset, step && emit && token.error, halted)
   `ASSERT_NEXT(a_img_halts, clock, reset, step && emit && token.last_image, halted)
   `ASSERT_IMPLIES(a_img_line, clock, reset, rsp_valid && rsp_last_of_image, rsp_last_of_line)
   `ASSERT_IMPLIES(a_err_clean, clock, reset, rsp_valid && rsp_error_flag, rsp_run_length == '0)
endmodule

[bench/tb_rle_line_mode_decoder.sv]
`timescale 1ns / 1ps

module tb_rle_line_mode_decoder;
   import rlelm_pkg::*;

   typedef struct {
      logic [11:0] column;
      logic [12:0] length;
      logic        kind;
      logic [7:0]  value;
      logic        last_line;
      logic        last_image;
      logic        error;
   } run_token;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_stream_bit = 1'b0;
   logic        req_start_of_image = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [11:0] rsp_run_column;
   logic [12:0] rsp_run_length;
   logic        rsp_run_kind;
   logic [7:0]  rsp_fill_value;
   logic        rsp_last_of_line;
   logic        rsp_last_of_image;
   logic        rsp_error_flag;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [12:0] csr_data = 13'd0;

   rle_line_mode_decoder u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Decoder shadow state.
   int unsigned     cfg_width, cfg_total, cfg_bits;
   phase_type       phase;
   mode_type        mode;
   int unsigned     shift_acc, bit_count, pix_left, next_col, line_idx;
   int unsigned     bg_value, held_val, pending_len;
   bit              stopped;

   run_token        expected_runs[$];
   int              error_count = 0;
   int              token_count = 0;
   int              bit_count_sent = 0;
   int              image_count = 0;
   longint          cycle_count = 0;
   bit              rsp_stall_on = 1'b1;

   function automatic int unsigned eff_width();
      return cfg_width == 0 ? 1 : (cfg_width > 4096 ? 4096 : cfg_width);
   endfunction

   function automatic int unsigned eff_total();
      return cfg_total == 0 ? 1 : (cfg_total > 4096 ? 4096 : cfg_total);
   endfunction

   function automatic int unsigned eff_bits();
      return cfg_bits == 0 ? 1 : (cfg_bits > 8 ? 8 : cfg_bits);
   endfunction

   function automatic void push_run(int unsigned col, int unsigned len, bit kind,
                                    int unsigned val, bit lol, bit loi, bit err);
      run_token t;
      t.column = col[11:0];
      t.length = len[12:0];
      t.kind = kind;
      t.value = val[7:0];
      t.last_line = lol;
      t.last_image = loi;
      t.error = err;
      expected_runs.push_back(t);
   endfunction

   function automatic void open_line();
      phase = PH_MODE;
      next_col = 0;
      pix_left = eff_width();
   endfunction

   function automatic bit close_line();
      line_idx++;
      if (line_idx >= eff_total()) begin
         stopped = 1'b1;
         return 1'b1;
      end
      open_line();
      return 1'b0;
   endfunction

   function automatic void flag_error();
      stopped = 1'b1;
      push_run(0, 0, 0, 0, 0, 0, 1);
   endfunction

   function automatic void line_marker();
      int unsigned col;
      bit loi;
      col = next_col;
      loi = close_line();
      push_run(col, 0, 0, bg_value, 1, loi, 0);
   endfunction

   function automatic void decode_run(int unsigned len, bit kind, int unsigned val,
                                      bit can_end);
      int unsigned col;
      bit lol, loi;
      col = next_col;
      lol = 0;
      loi = 0;
      next_col += len;
      pix_left -= len;
      if (can_end && pix_left == 0) begin
         lol = 1;
         loi = close_line();
      end
      push_run(col, len, kind, val, lol, loi, 0);
   endfunction

   function automatic int unsigned bits_needed();
      case (phase)
         PH_MODE: return 3;
         PH_START: return mode == MODE_START_END ? 9 : 8;
         PH_END: return 8;
         PH_FLAG: return 1;
         PH_COPYLEN: return mode == MODE_DELTA_STOP ? 5 : 6;
         PH_LEN: begin
            case (mode)
               MODE_BASIC: return 4;
               MODE_BASIC_STOP: return 6;
               MODE_BASIC_ZERO: return held_val == bg_value ? 8 : 3;
               default: return 3;
            endcase
         end
         default: return eff_bits();
      endcase
   endfunction

   function automatic void predict_bit(bit sbit, bit sof);
      int unsigned v, len, col;
      bit lol, loi;
      if (sof) begin
         stopped = 1'b0;
         phase = PH_BG;
         mode = MODE_EMPTY;
         shift_acc = 0;
         bit_count = 0;
         pix_left = 0;
         next_col = 0;
         line_idx = 0;
         bg_value = 0;
         held_val = 0;
         pending_len = 0;
      end
      if (stopped) return;
      shift_acc |= int'(sbit) << (bit_count & 15);
      bit_count++;
      if (bit_count < bits_needed()) return;
      v = shift_acc;
      shift_acc = 0;
      bit_count = 0;
      case (phase)
         PH_BG: begin
            bg_value = v & 8'hFF;
            open_line();
         end
         PH_MODE: begin
            mode = mode_type'(v[2:0]);
            case (mode)
               MODE_EMPTY: decode_run(pix_left, 0, bg_value, 1);
               MODE_BASIC: phase = PH_LEN;
               MODE_DELTA, MODE_DELTA_STOP: phase = PH_FLAG;
               MODE_BASIC_STOP, MODE_START_END: phase = PH_START;
               MODE_BASIC_ZERO: phase = PH_ZVAL;
               default: flag_error();
            endcase
         end
         PH_START: begin
            phase = (mode == MODE_START_END) ? PH_END : PH_LEN;
            if (v != 0) begin
               if (v > pix_left) flag_error();
               else decode_run(v, 0, bg_value, mode != MODE_START_END);
            end
         end
         PH_END: begin
            if (v > pix_left) flag_error();
            else begin
               phase = PH_LEN;
               if (v == 0) begin
                  if (pix_left == 0) line_marker();
               end else begin
                  // The end run sits at the right edge, ahead of the middle runs.
                  col = next_col + pix_left - v;
                  lol = 0;
                  loi = 0;
                  pix_left -= v;
                  if (pix_left == 0) begin
                     lol = 1;
                     loi = close_line();
                  end
                  push_run(col, v, 0, bg_value, lol, loi, 0);
               end
            end
         end
         PH_FLAG: phase = v ? PH_COPYLEN : PH_LEN;
         PH_COPYLEN: begin
            len = v + 1;
            if (len > pix_left) flag_error();
            else begin
               phase = PH_FLAG;
               if (line_idx == 0) decode_run(len, 0, bg_value, 1);
               else decode_run(len, 1, 0, 1);
            end
         end
         PH_LEN: begin
            if ((mode == MODE_BASIC_STOP || mode == MODE_DELTA_STOP) && v == 0) begin
               line_marker();
            end else begin
               len = (mode == MODE_BASIC_STOP || mode == MODE_DELTA_STOP) ? v : v + 1;
               if (len > pix_left) flag_error();
               else if (mode == MODE_BASIC_ZERO) begin
                  phase = PH_ZVAL;
                  decode_run(len, 0, held_val, 1);
               end else begin
                  pending_len = len;
                  phase = PH_VAL;
               end
            end
         end
         PH_VAL: begin
            if (mode == MODE_DELTA || mode == MODE_DELTA_STOP) phase = PH_FLAG;
            else if (mode == MODE_BASIC_ZERO) phase = PH_ZVAL;
            else phase = PH_LEN;
            decode_run(pending_len, 0, v & 8'hFF, 1);
         end
         PH_ZVAL: begin
            held_val = v & 8'hFF;
            phase = PH_LEN;
         end
         default: flag_error();
      endcase
   endfunction

   // Valid stays high between back-to-back beats; it drops only for an idle gap.
   task automatic send_bit(bit sbit, bit sof);
      int gap;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_stream_bit <= sbit;
      req_start_of_image <= sof;
      do @(posedge clock); while (!req_ready);
      predict_bit(sbit, sof);
      bit_count_sent++;
      @(negedge clock);
   endtask

   task automatic send_field(int unsigned val, int unsigned nbits, bit sof = 1'b0);
      for (int i = 0; i < nbits; i++) send_bit(val[i], sof && i == 0);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val[12:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_LINE_WIDTH: cfg_width = val & 13'h1FFF;
         CSR_LINE_TOTAL: cfg_total = val & 13'h1FFF;
         CSR_PIXEL_BITS: cfg_bits = val & 4'hF;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_runs.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_geometry(int unsigned w, int unsigned t, int unsigned b);
      drain();
      write_reg(CSR_LINE_WIDTH, w);
      write_reg(CSR_LINE_TOTAL, t);
      write_reg(CSR_PIXEL_BITS, b);
   endtask

   // Sends one image with mostly well-formed random lines.
   task automatic send_random_image();
      int unsigned w, nb, left, len, m;
      bit sane;
      w = eff_width();
      nb = eff_bits();
      image_count++;
      send_field($urandom, nb, 1'b1);
      for (int ln = 0; ln < eff_total(); ln++) begin
         if (stopped) break;
         sane = $urandom_range(0, 9) != 0;
         m = $urandom_range(0, 7);
         if (sane && m == 7) m = $urandom_range(0, 6);
         send_field(m, 3);
         left = w;
         if (m == 7) break;
         if (m == 0) continue;
         if (m == 3 || m == 4) begin
            len = sane ? $urandom_range(0, left < 255 ? left : 255) : $urandom_range(0, 511);
            send_field(len, m == 4 ? 9 : 8);
            left = (len <= left) ? left - len : 0;
            if (m == 4) begin
               len = sane ? $urandom_range(0, left < 255 ? left : 255) : $urandom;
               send_field(len, 8);
               left = (len <= left) ? left - len : 0;
            end
         end
         // Run loop; stops when the shadow line ends or the decoder halts.
         while (!stopped && line_idx == ln && phase != PH_MODE && left > 0) begin
            case (mode)
               MODE_BASIC_ZERO: begin
                  send_field($urandom_range(0, 1) ? bg_value : $urandom, nb);
                  len = sane ? $urandom_range(0, left - 1) : $urandom;
                  send_field(len, bits_needed());
               end
               MODE_DELTA, MODE_DELTA_STOP: begin
                  if ($urandom_range(0, 1)) begin
                     send_bit(1, 0);
                     send_field(sane ? $urandom_range(0, left - 1) : $urandom, bits_needed());
                  end else begin
                     send_bit(0, 0);
                     len = mode == MODE_DELTA_STOP ? $urandom_range(0, 7) :
                           $urandom_range(0, 7);
                     if (sane && len >= left + (mode == MODE_DELTA_STOP)) len = 0;
                     send_field(len, 3);
                     if (!stopped && phase == PH_VAL) send_field($urandom, nb);
                  end
               end
               default: begin
                  len = $urandom_range(0, (1 << bits_needed()) - 1);
                  if (sane && mode != MODE_BASIC_STOP && len >= left) len = left - 1;
                  if (sane && mode == MODE_BASIC_STOP && len > left) len = left;
                  send_field(len, bits_needed());
                  if (!stopped && phase == PH_VAL) send_field($urandom, nb);
               end
            endcase
            left = (line_idx == ln) ? pix_left : 0;
         end
         if (!stopped && line_idx == ln && phase != PH_MODE) break;
      end
   endtask

   task automatic test_directed();
      set_geometry(8, 3, 8);
      send_bit(1, 0);                   // ignored while waiting for a start
      send_field(8'hA5, 8, 1'b1);
      send_field(MODE_EMPTY, 3);
      send_field(MODE_DELTA, 3);
      send_bit(1, 0); send_field(2, 6); // copy on a later line
      send_bit(0, 0); send_field(4, 3); send_field(8'hFF, 8);
      send_field(MODE_BAD, 3);          // bad mode halts
      send_bit(0, 0);
      // Start-end line whose start run fills it and end run is zero.
      send_field(8'h00, 8, 1'b1);
      send_field(MODE_START_END, 3); send_field(8, 9); send_field(0, 8);
      send_field(MODE_BASIC_STOP, 3); send_field(2, 8); send_field(0, 6);
      send_field(MODE_DELTA, 3); send_bit(1, 0); send_field(63, 6); // overlong
   endtask

   task automatic test_extremes();
      set_geometry(4096, 1, 1);
      send_field(1, 1, 1'b1);
      send_field(MODE_EMPTY, 3);
      set_geometry(0, 0, 0);
      send_field(0, 1, 1'b1);
      send_field(MODE_DELTA, 3); send_bit(1, 0); send_field(0, 6);
      set_geometry(13'h1FFF, 13'h1FFF, 15);
      send_field(8'h3C, 8, 1'b1);
      send_field(MODE_START_END, 3); send_field(511, 9); send_field(255, 8);
      send_field(MODE_BAD, 3);
   endtask

   task automatic test_random();
      while (bit_count_sent < 1000) begin
         case ($urandom_range(0, 3))
            0: set_geometry($urandom_range(1, 12), $urandom_range(1, 4), $urandom_range(1, 8));
            1: set_geometry($urandom_range(1, 40), $urandom_range(1, 3), $urandom_range(1, 8));
            2: set_geometry($urandom_range(1, 300), $urandom_range(1, 2),
                            $urandom_range(0, 15));
            default: set_geometry($urandom_range(1, 6), 4, $urandom_range(1, 3));
         endcase
         rsp_stall_on = $urandom_range(0, 3) != 0;
         repeat ($urandom_range(1, 3)) send_random_image();
         if ($urandom_range(0, 4) == 0) repeat (10) send_bit($urandom, 0);
      end
   endtask

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         run_token e;
         token_count++;
         if (expected_runs.size() == 0) begin
            $display("%0t: unexpected token col %0d len %0d", $realtime, rsp_run_column,
                     rsp_run_length);
            error_count++;
         end else begin
            e = expected_runs.pop_front();
            if (e.column !== rsp_run_column || e.length !== rsp_run_length ||
                e.kind !== rsp_run_kind || e.value !== rsp_fill_value ||
                e.last_line !== rsp_last_of_line || e.last_image !== rsp_last_of_image ||
                e.error !== rsp_error_flag) begin
               $display("%0t: expected col %0d len %0d kind %0b val %0h lol %0b loi %0b err %0b",
                        $realtime, e.column, e.length, e.kind, e.value, e.last_line,
                        e.last_image, e.error);
               $display("%0t: actual   col %0d len %0d kind %0b val %0h lol %0b loi %0b err %0b",
                        $realtime, rsp_run_column, rsp_run_length, rsp_run_kind,
                        rsp_fill_value, rsp_last_of_line, rsp_last_of_image, rsp_error_flag);
               error_count++;
            end
         end
      end
   end

   // Random receiver back-pressure.
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         stall = rsp_stall_on ? $urandom_range(0, 5) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("rle_line_mode_decoder verification failed");
         $finish;
      end
   end

   initial begin
      cfg_width = 1;
      cfg_total = 1;
      cfg_bits = 8;
      phase = PH_BG;
      mode = MODE_EMPTY;
      shift_acc = 0;
      bit_count = 0;
      pix_left = 0;
      next_col = 0;
      line_idx = 0;
      bg_value = 0;
      held_val = 0;
      pending_len = 0;
      stopped = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_extremes();
      test_random();
      drain();
      repeat (20) @(negedge clock);
      $display("Sent %0d stream bits in %0d images; checked %0d run tokens.",
               bit_count_sent, image_count, token_count);
      if (error_count == 0 && expected_runs.size() == 0) begin
         $display("rle_line_mode_decoder verification clean");
      end else begin
         $display("rle_line_mode_decoder verification failed");
      end
      $finish;
   end
endmodule

[rle_line_mode_decoder.f]
+incdir+src
src/rlelm_pkg.sv
src/rlelm_csr.sv
src/rlelm_parser.sv
src/rle_line_mode_decoder.sv
bench/tb_rle_line_mode_decoder.sv
